### rtl/core/pscnt_pkg.sv
package pscnt_pkg;

	// character and count widths
	localparam int CH_W        = 8;
	localparam int CNT_W       = 21;
	localparam int OUT_TDATA_W = 24;

	// default store capacity
	localparam int MAX_LEN_DEF = 2048;

	// count saturation value
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

### rtl/core/palindromic_substring_counter_core.sv
// Palindromic substring counter. Characters arrive on the slave stream one
// transaction per cycle, the character in tdata[7:0] and tlast marking the
// final character of a string, and are written into a character store of
// MAX_LEN entries. Characters arriving once the store is full are dropped and
// the truncated flag of the result is set. After the final character the
// block counts every palindromic substring of length two or more by expanding
// around each even and each odd centre, each expansion stopping at the first
// mismatching pair, and presents one result transaction on the master stream
// holding the count (saturating at the largest 21-bit value) and the
// truncated flag. Loading runs at one character per cycle. In the count phase
// each character pair compared passes through the ST_ISSUE and ST_CMP states,
// set by the registered read of the store: ST_ISSUE issues the read of both
// ends and ST_CMP compares them. For a stored length n >= 2 there are 2n - 3
// expansions, each ending on a mismatch or at an edge of the string. The
// result then waits in ST_DONE until the output register is free or
// draining. No input is taken during the count phase or while the result
// waits in ST_DONE.
// The store is kept twice so both ends of a pair are read in the same cycle;
// it needs no clearing after reset since only entries written for the
// current string are read.
module palindromic_substring_counter_core
	import pscnt_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CH_W-1:0]        s_axis_tdata,  // [7:0] ch
	input  logic                   s_axis_tlast,  // last
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [20:0] pal_count, [21] truncated
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LEN);

	// controller states
	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [LW-1:0]    len_q;
	logic             ovf_q;
	logic [AW-1:0]    c_q;     // right index of current centre
	logic             odd_q;   // odd centre of c_q in progress
	logic [AW-1:0]    l_q;
	logic [AW-1:0]    r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_trunc_q;

	logic [CH_W-1:0]  rd_l;
	logic [CH_W-1:0]  rd_r;
	logic             in_acc;
	logic             store_full;
	logic [LW-1:0]    len_nx;
	logic             pair_eq;
	logic             walk_on;
	logic [LW-1:0]    c_nx;
	logic             out_load;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign store_full    = (len_q == LEN_FULL);
	assign len_nx        = store_full ? len_q : len_q + LW'(1);

	// both copies take every stored character
	pscnt_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_ram_l (
		.clk   (clk),
		.we    (in_acc && !store_full),
		.waddr (len_q[AW-1:0]),
		.wdata (s_axis_tdata),
		.raddr (l_q),
		.rdata (rd_l)
	);

	pscnt_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_ram_r (
		.clk   (clk),
		.we    (in_acc && !store_full),
		.waddr (len_q[AW-1:0]),
		.wdata (s_axis_tdata),
		.raddr (r_q),
		.rdata (rd_r)
	);

	// compare stage: read data belongs to l_q / r_q issued last cycle
	assign pair_eq = (rd_l == rd_r);
	assign walk_on = pair_eq && (l_q != '0) && ((LW'(r_q) + LW'(1)) < len_q);
	assign c_nx    = LW'(c_q) + LW'(1);

	// result enters the output register once it is free or draining
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			c_q         <= '0;
			odd_q       <= 1'b0;
			l_q         <= '0;
			r_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_cnt_q   <= '0;
			out_trunc_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						len_q <= len_nx;
						ovf_q <= ovf_q | store_full;
						if (s_axis_tlast) begin
							cnt_q <= '0;
							c_q   <= AW'(1);
							odd_q <= 1'b0;
							l_q   <= '0;
							r_q   <= AW'(1);
							// fewer than two characters holds no pair
							state_q <= (len_nx < LW'(2)) ? ST_DONE : ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pair_eq && cnt_q != CNT_MAX) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (walk_on) begin
						l_q     <= l_q - AW'(1);
						r_q     <= r_q + AW'(1);
						state_q <= ST_ISSUE;
					end else if (!odd_q && LW'(c_q) >= LW'(2)) begin
						// odd centre: compare c-2 with c
						odd_q   <= 1'b1;
						l_q     <= c_q - AW'(2);
						r_q     <= c_q;
						state_q <= ST_ISSUE;
					end else if (c_nx < len_q) begin
						// even centre between c and c+1
						odd_q   <= 1'b0;
						c_q     <= c_nx[AW-1:0];
						l_q     <= c_q;
						r_q     <= c_nx[AW-1:0];
						state_q <= ST_ISSUE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (out_load) begin
						out_cnt_q   <= cnt_q;
						out_trunc_q <= ovf_q;
						len_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - CNT_W - 1)'(0), out_trunc_q, out_cnt_q};

endmodule

### rtl/core/pscnt_ram.sv
module pscnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### test/palindromic_substring_counter_core_tb.sv
module palindromic_substring_counter_core_tb;
	import pscnt_pkg::*;

	localparam int STORE_DEPTH = MAX_LEN_DEF;
	localparam int SA_W        = $clog2(STORE_DEPTH);
	localparam int RAND_ITEMS  = 300;
	localparam int CALM_AFTER  = 240;
	localparam int IDLE_LIMIT  = 400000;
	localparam int DRAIN_WAIT  = 64;
	localparam int PLAN_ROWS   = 17;

	typedef struct packed {
		logic             trunc;
		logic [CNT_W-1:0] cnt;
	} pal_result_t;

	// one row drives reps characters, ch advancing by step each time
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [CH_W-1:0]  step;
		logic [11:0]      reps;
		logic             fin;
		logic             typed;
		logic [CNT_W-1:0] cnt;
		logic             trunc;
	} run_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [CH_W-1:0]        s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor state
	logic [CH_W-1:0] text_buf [STORE_DEPTH];
	int unsigned     text_len = 0;
	bit              text_clipped = 1'b0;
	pal_result_t     pending_counts [$];

	// hand-written expectation for the item on the bus
	bit               typed_on = 1'b0;
	logic [CNT_W-1:0] typed_cnt = '0;
	logic             typed_trunc = 1'b0;

	bit       calm = 1'b0;
	int       errors = 0;
	int       idle_cycles = 0;
	int       stall_left = 0;
	run_row_t plan [PLAN_ROWS];

	palindromic_substring_counter_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// matching pairs found walking outwards from one centre
	function automatic int unsigned walk_hits(input int unsigned lo, input int unsigned hi);
		int unsigned hits;
		int unsigned l;
		int unsigned r;
		bit          go;
		hits = 0;
		l = lo;
		r = hi;
		go = 1'b1;
		while (go) begin
			if (r >= text_len || text_buf[l[SA_W-1:0]] != text_buf[r[SA_W-1:0]]) begin
				go = 1'b0;
			end else begin
				hits++;
				if (l == 0) begin
					go = 1'b0;
				end else begin
					l--;
					r++;
				end
			end
		end
		return hits;
	endfunction

	function automatic logic [CNT_W-1:0] pal_tally();
		longint unsigned total;
		int unsigned     c;
		total = 0;
		for (c = 1; c < text_len; c++) begin
			total += walk_hits(c - 1, c);
			if (c >= 2)
				total += walk_hits(c - 2, c);
		end
		if (total > CNT_MAX)
			total = longint'(CNT_MAX);
		return total[CNT_W-1:0];
	endfunction

	// input side: store characters, predict on the final one
	always @(posedge clk) begin : char_monitor
		pal_result_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (text_len < STORE_DEPTH) begin
				text_buf[text_len[SA_W-1:0]] = s_axis_tdata;
				text_len++;
			end else begin
				text_clipped = 1'b1;
			end
			if (s_axis_tlast) begin
				r.cnt = pal_tally();
				r.trunc = text_clipped;
				if (typed_on) begin
					r.cnt = typed_cnt;
					r.trunc = typed_trunc;
				end
				pending_counts.push_back(r);
				text_len = 0;
				text_clipped = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		pal_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_counts.size() == 0) begin
				$display("%0t unexpected result: count %0d truncated %0d", $time,
					m_axis_tdata[CNT_W-1:0], m_axis_tdata[CNT_W]);
				errors++;
			end else begin
				want = pending_counts.pop_front();
				if (m_axis_tdata[CNT_W-1:0] !== want.cnt) begin
					$display("%0t pal_count mismatch: expected %0d actual %0d", $time,
						want.cnt, m_axis_tdata[CNT_W-1:0]);
					errors++;
				end
				if (m_axis_tdata[CNT_W] !== want.trunc) begin
					$display("%0t truncated mismatch: expected %0d actual %0d", $time,
						want.trunc, m_axis_tdata[CNT_W]);
					errors++;
				end
			end
		end
	end

	// result side back-pressure in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_char(input logic [CH_W-1:0] c, input logic fin, input bit typed,
		input logic [CNT_W-1:0] tc, input logic tt);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= fin;
		typed_on = typed && fin;
		typed_cnt = tc;
		typed_trunc = tt;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	initial begin : stimulus
		int              i;
		int              k;
		int              len;
		int              n_sym;
		int              rand_sent;
		logic [CH_W-1:0] c;
		logic [CH_W-1:0] sym [4];

		//            ch     step   reps  fin   typed cnt    trunc
		plan[0]  = '{8'h01, 8'h00, 12'd1,    1'b1, 1'b1, 21'd0,     1'b0}; // single char
		plan[1]  = '{8'hFF, 8'h00, 12'd2,    1'b1, 1'b1, 21'd1,     1'b0};
		plan[2]  = '{8'h61, 8'h00, 12'd1,    1'b0, 1'b0, 21'd0,     1'b0};
		plan[3]  = '{8'h62, 8'h00, 12'd2,    1'b0, 1'b0, 21'd0,     1'b0};
		plan[4]  = '{8'h61, 8'h00, 12'd1,    1'b1, 1'b1, 21'd2,     1'b0}; // abba
		plan[5]  = '{8'h61, 8'h00, 12'd1,    1'b0, 1'b0, 21'd0,     1'b0};
		plan[6]  = '{8'h62, 8'h00, 12'd1,    1'b0, 1'b0, 21'd0,     1'b0};
		plan[7]  = '{8'h61, 8'h00, 12'd1,    1'b1, 1'b1, 21'd1,     1'b0}; // aba
		plan[8]  = '{8'h00, 8'h00, 12'd2,    1'b1, 1'b1, 21'd1,     1'b0}; // zero bytes
		plan[9]  = '{8'h5A, 8'h00, 12'd64,   1'b1, 1'b1, 21'd2016,  1'b0}; // one repeated char
		plan[10] = '{8'h01, 8'h01, 12'd2049, 1'b1, 1'b1, 21'd0,     1'b1}; // final char dropped
		plan[11] = '{8'h41, 8'h00, 12'd1,    1'b1, 1'b1, 21'd0,     1'b0}; // cleared after result
		plan[12] = '{8'h7F, 8'h00, 12'd3,    1'b0, 1'b0, 21'd0,     1'b0};
		plan[13] = '{8'h80, 8'h00, 12'd1,    1'b0, 1'b0, 21'd0,     1'b0};
		plan[14] = '{8'h7F, 8'h00, 12'd3,    1'b1, 1'b0, 21'd0,     1'b0};
		plan[15] = '{8'hAA, 8'hAB, 12'd7,    1'b1, 1'b0, 21'd0,     1'b0};
		plan[16] = '{8'h03, 8'hFF, 12'd5,    1'b1, 1'b0, 21'd0,     1'b0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < PLAN_ROWS; i++) begin
			c = plan[i].ch;
			for (k = 0; k < plan[i].reps; k++) begin
				send_char(c, plan[i].fin && (k == plan[i].reps - 1), plan[i].typed,
					plan[i].cnt, plan[i].trunc);
				c = c + plan[i].step;
			end
		end

		// random strings, mostly short and over small alphabets
		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			k = $urandom_range(0, 9);
			if (k == 0)
				n_sym = 1;
			else if (k < 7)
				n_sym = $urandom_range(2, 4);
			else
				n_sym = 0;
			for (i = 0; i < 4; i++)
				sym[i] = CH_W'($urandom_range(1, 255));
			k = $urandom_range(0, 99);
			if (k < 85)
				len = $urandom_range(1, 24);
			else if (k < 98)
				len = $urandom_range(25, 96);
			else
				len = $urandom_range(150, 260);
			for (i = 0; i < len; i++) begin
				if (n_sym == 0)
					c = CH_W'($urandom_range(1, 255));
				else
					c = sym[2'($urandom_range(0, n_sym - 1))];
				send_char(c, i == len - 1, 1'b0, '0, 1'b0);
				rand_sent++;
				if (rand_sent >= CALM_AFTER)
					calm = 1'b1;
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
rtl/core/pscnt_pkg.sv
rtl/core/pscnt_ram.sv
rtl/core/palindromic_substring_counter_core.sv
test/palindromic_substring_counter_core_tb.sv
